// ===== rtl/mwc_pkg.sv =====
package mwc_pkg;

	localparam int DATA_W    = 32;
	localparam int HALF_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_CNT_W = $clog2(DATA_W);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SEED_W = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SEED_Z = CFG_IDX_W'(1);

	localparam logic [DATA_W-1:0] RESET_W = 32'd521288629;
	localparam logic [DATA_W-1:0] RESET_Z = 32'd362436069;
	localparam logic [HALF_W-1:0] MUL_Z   = 16'd36969;
	localparam logic [HALF_W-1:0] MUL_W   = 16'd18000;

	localparam logic MODE_FULL   = 1'b0;
	localparam logic MODE_RANGED = 1'b1;

	typedef struct packed {
		logic load_req;
		logic advance;
		logic div_start;
		logic div_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic ranged;
		logic div_last;
	} dp_sts_t;

endpackage

// ===== rtl/mwc_req_if.sv =====
interface mwc_req_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [mwc_pkg::DATA_W-1:0] lower_bound;
	logic [mwc_pkg::DATA_W-1:0] upper_bound;

	modport source(output valid, mode, lower_bound, upper_bound, input ready);
	modport sink(input valid, mode, lower_bound, upper_bound, output ready);
endinterface

// ===== rtl/mwc_rsp_if.sv =====
interface mwc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [mwc_pkg::DATA_W-1:0] value;

	modport source(output valid, value, input ready);
	modport sink(input valid, value, output ready);
endinterface

// ===== rtl/mwc_ctrl.sv =====
module mwc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output mwc_pkg::ctrl_cmd_t cmd,
	input  mwc_pkg::dp_sts_t   sts
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DRAW = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DRAW;
				end
			end
			ST_DRAW: begin
				// empty range keeps both halves
				cmd.advance   = !sts.empty;
				cmd.div_start = sts.ranged;
				state_d       = sts.ranged ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/mwc_dp.sv =====
module mwc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mwc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mwc_pkg::DATA_W-1:0]          cfg_data,
	input  logic                                mode,
	input  logic [mwc_pkg::DATA_W-1:0]          lower_bound,
	input  logic [mwc_pkg::DATA_W-1:0]          upper_bound,
	input  mwc_pkg::ctrl_cmd_t                  cmd,
	output mwc_pkg::dp_sts_t                    sts,
	output logic [mwc_pkg::DATA_W-1:0]          value
);

	logic [mwc_pkg::DATA_W-1:0]    w_q, z_q;
	logic                          mode_q;
	logic [mwc_pkg::DATA_W-1:0]    lo_q, hi_q;
	logic [mwc_pkg::DATA_W-1:0]    dvd_q, span_q, rem_q, out_q;
	logic [mwc_pkg::DIV_CNT_W-1:0] cnt_q;

	logic [mwc_pkg::DATA_W-1:0] z_prod, w_prod, z_next, w_next, draw_next;
	logic [mwc_pkg::DATA_W:0]   trial;
	logic                       trial_ge;
	logic [mwc_pkg::DATA_W-1:0] rem_next, result;
	logic                       empty;
	logic                       cfg_nz;

	// one lag-1 multiply-with-carry step per half
	assign z_prod = {16'd0, mwc_pkg::MUL_Z} * {16'd0, z_q[mwc_pkg::HALF_W-1:0]};
	assign w_prod = {16'd0, mwc_pkg::MUL_W} * {16'd0, w_q[mwc_pkg::HALF_W-1:0]};
	assign z_next = z_prod + {16'd0, z_q[mwc_pkg::DATA_W-1:mwc_pkg::HALF_W]};
	assign w_next = w_prod + {16'd0, w_q[mwc_pkg::DATA_W-1:mwc_pkg::HALF_W]};
	assign draw_next = {z_next[mwc_pkg::HALF_W-1:0], 16'd0} + w_next;

	// restoring remainder, one dividend bit per step
	assign trial    = {rem_q, dvd_q[mwc_pkg::DATA_W-1]};
	assign trial_ge = trial >= {1'b0, span_q};
	always_comb begin
		if (trial_ge) begin
			rem_next = mwc_pkg::DATA_W'(trial - {1'b0, span_q});
		end else begin
			rem_next = trial[mwc_pkg::DATA_W-1:0];
		end
	end

	assign empty        = (mode_q == mwc_pkg::MODE_RANGED) && (lo_q >= hi_q);
	assign sts.empty    = empty;
	assign sts.ranged   = (mode_q == mwc_pkg::MODE_RANGED) && !empty;
	assign sts.div_last = (cnt_q == mwc_pkg::DIV_LAST);

	always_comb begin
		if (mode_q == mwc_pkg::MODE_FULL) begin
			result = dvd_q;
		end else if (empty) begin
			result = lo_q;
		end else begin
			result = lo_q + rem_q;
		end
	end

	assign value  = out_q;
	assign cfg_nz = (cfg_data != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= mwc_pkg::RESET_W;
			z_q <= mwc_pkg::RESET_Z;
		end else begin
			if (cmd.advance) begin
				w_q <= w_next;
				z_q <= z_next;
			end else if (cfg_we && cfg_nz) begin
				if (cfg_index == mwc_pkg::REG_SEED_W) begin
					w_q <= cfg_data;
				end else if (cfg_index == mwc_pkg::REG_SEED_Z) begin
					z_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q <= mode;
			lo_q   <= lower_bound;
			hi_q   <= upper_bound;
		end
		if (cmd.advance) begin
			dvd_q <= draw_next;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[mwc_pkg::DATA_W-2:0], 1'b0};
		end
		if (cmd.div_start) begin
			span_q <= hi_q - lo_q;
			rem_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.load_out) begin
			out_q <= result;
		end
	end

endmodule

// ===== rtl/mwc_random_ranged_core.sv =====
// order: input transfer, a draw state, for a ranged draw 32 remainder steps, then a
// result state that loads the output once the output register is free
// input: a new item is taken only once the last result is loaded into the output,
// and a new item is taken while that result waits
// reset: asynchronous active low, loads both halves with their default seeds
module mwc_random_ranged_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwc_pkg::DATA_W-1:0]    cfg_data,
	mwc_req_if.sink                       req,
	mwc_rsp_if.source                     rsp
);

	mwc_pkg::ctrl_cmd_t cmd;
	mwc_pkg::dp_sts_t   sts;

	mwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mwc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mode        (req.mode),
		.lower_bound (req.lower_bound),
		.upper_bound (req.upper_bound),
		.cmd         (cmd),
		.sts         (sts),
		.value       (rsp.value)
	);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import mwc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int END_WAIT    = 40;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	mwc_req_if req_ch ();
	mwc_rsp_if rsp_ch ();

	mwc_random_ranged_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// predictor state
	logic [DATA_W-1:0] pred_w;
	logic [DATA_W-1:0] pred_z;
	logic [DATA_W-1:0] expected_values[$];
	logic [DATA_W-1:0] want_value;

	logic idle_on;
	int   hold_req_cnt;
	int   hold_seen;
	int   hold_left;
	int   stall_cycles;
	int   mismatches;
	int   sent_count;
	int   ranged_count;
	int   empty_count;
	int   checked_count;
	int   seed_settings;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [DATA_W-1:0] mwc_next_draw();
		pred_z = 32'(MUL_Z) * 32'(pred_z[15:0]) + 32'(pred_z[31:16]);
		pred_w = 32'(MUL_W) * 32'(pred_w[15:0]) + 32'(pred_w[31:16]);
		return (pred_z << 16) + pred_w;
	endfunction

	function automatic logic [DATA_W-1:0] predict_value(input logic m,
			input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
		logic [DATA_W-1:0] r;
		if (m == MODE_FULL) begin
			return mwc_next_draw();
		end else if (lo >= hi) begin
			// empty range leaves both halves alone
			return lo;
		end else begin
			r = mwc_next_draw();
			return lo + (r % (hi - lo));
		end
	endfunction

	task automatic log_mismatch(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s expected %h got %h", what, want, got);
	endtask

	task automatic send_draw(input logic m, input logic [DATA_W-1:0] lo,
			input logic [DATA_W-1:0] hi);
		while (idle_on && $urandom_range(0, 99) < 11) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.mode        <= m;
		req_ch.lower_bound <= lo;
		req_ch.upper_bound <= hi;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		expected_values.push_back(predict_value(m, lo, hi));
		sent_count++;
		if (m == MODE_RANGED) begin
			if (lo >= hi)
				empty_count++;
			else
				ranged_count++;
		end
	endtask

	// drop valid and let every outstanding result come back
	task automatic end_batch();
		req_ch.valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (data != '0) begin
			if (idx == REG_SEED_W)
				pred_w = data;
			else if (idx == REG_SEED_Z)
				pred_z = data;
		end
		@(posedge clk);
	endtask

	task automatic set_seeds(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] z);
		end_batch();
		write_reg(REG_SEED_W, w);
		write_reg(REG_SEED_Z, z);
		seed_settings++;
	endtask

	task automatic test_reset_seeds();
		send_draw(MODE_FULL, 32'h0000_0000, 32'hffff_ffff);
		send_draw(MODE_FULL, 32'hffff_ffff, 32'h0000_0000);
		send_draw(MODE_FULL, 32'h5555_5555, 32'haaaa_aaaa);
		end_batch();
	endtask

	task automatic test_range_edges();
		send_draw(MODE_RANGED, 32'h0000_0000, 32'h0000_0000);
		send_draw(MODE_RANGED, 32'hffff_ffff, 32'hffff_ffff);
		send_draw(MODE_RANGED, 32'hffff_ffff, 32'h0000_0000);
		send_draw(MODE_RANGED, 32'h0000_0005, 32'h0000_0004);
		send_draw(MODE_RANGED, 32'h0000_0007, 32'h0000_0008);
		send_draw(MODE_RANGED, 32'hffff_fffe, 32'hffff_ffff);
		send_draw(MODE_RANGED, 32'h0000_0000, 32'hffff_ffff);
		send_draw(MODE_RANGED, 32'h0000_0001, 32'hffff_ffff);
		send_draw(MODE_RANGED, 32'h0000_0000, 32'h0001_0000);
		send_draw(MODE_RANGED, 32'h8000_0000, 32'hffff_ffff);
		end_batch();
	endtask

	task automatic test_seed_writes();
		set_seeds(32'h0000_0001, 32'hffff_ffff);
		send_draw(MODE_FULL, 32'h0, 32'h0);
		send_draw(MODE_RANGED, 32'h0000_0010, 32'h0000_0400);
		// zero seeds must not touch the halves
		set_seeds(32'h0000_0000, 32'h0000_0000);
		send_draw(MODE_FULL, 32'h0, 32'h0);
		send_draw(MODE_FULL, 32'h0, 32'h0);
		end_batch();
		write_reg(REG_SPARE_2, 32'hdead_beef);
		write_reg(REG_SPARE_3, 32'hffff_ffff);
		send_draw(MODE_FULL, 32'h0, 32'h0);
		set_seeds(32'hffff_ffff, 32'h0000_0001);
		send_draw(MODE_FULL, 32'h0, 32'h0);
		send_draw(MODE_RANGED, 32'h0000_0000, 32'h7fff_ffff);
		end_batch();
	endtask

	task automatic test_random_draws(input int count);
		logic              m;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		for (int i = 0; i < count; i++) begin
			m  = ($urandom_range(0, 9) < 6) ? MODE_RANGED : MODE_FULL;
			lo = $urandom;
			hi = $urandom;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: hi = lo + $urandom_range(1, 300);
				4: hi = lo - $urandom_range(0, 5);
				5: hi = lo + (32'd1 << $urandom_range(0, 31));
				6: begin
					lo = $urandom_range(0, 15);
					hi = 32'hffff_ffff - $urandom_range(0, 15);
				end
				default: ;
			endcase
			send_draw(m, lo, hi);
		end
		end_batch();
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_output_stall();
		idle_on      <= 1'b0;
		hold_req_cnt <= hold_req_cnt + 1;
		for (int i = 0; i < 24; i++)
			send_draw((i % 3 == 2) ? MODE_RANGED : MODE_FULL, $urandom, $urandom);
		end_batch();
		idle_on <= 1'b1;
		@(posedge clk);
	endtask

	// result checking and receiver ready
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_values.size() == 0) begin
				log_mismatch("unexpected result", 'x, rsp_ch.value);
			end else begin
				want_value = expected_values.pop_front();
				checked_count++;
				if (rsp_ch.value !== want_value)
					log_mismatch("value", want_value, rsp_ch.value);
			end
		end
		if (hold_req_cnt != hold_seen) begin
			hold_seen = hold_req_cnt;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (idle_on) begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= 11);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (req_ch.valid && req_ch.ready)
				|| (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("mwc_random_ranged_core test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		req_ch.valid       = 1'b0;
		req_ch.mode        = MODE_FULL;
		req_ch.lower_bound = '0;
		req_ch.upper_bound = '0;
		rsp_ch.ready       = 1'b0;
		pred_w             = RESET_W;
		pred_z             = RESET_Z;
		idle_on            = 1'b1;
		hold_req_cnt       = 0;
		hold_seen          = 0;
		hold_left          = 0;
		stall_cycles       = 0;
		mismatches         = 0;
		sent_count         = 0;
		ranged_count       = 0;
		empty_count        = 0;
		checked_count      = 0;
		seed_settings      = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_seeds();
		test_range_edges();
		test_seed_writes();

		set_seeds($urandom | 32'd1, $urandom | 32'd1);
		test_random_draws(250);
		// long stretch with both sides always ready
		idle_on <= 1'b0;
		set_seeds(32'h0000_0001, 32'h0000_0001);
		test_random_draws(150);
		idle_on <= 1'b1;
		set_seeds(32'hffff_ffff, 32'hffff_ffff);
		test_random_draws(200);
		set_seeds($urandom | 32'h8000_0000, $urandom | 32'd1);
		test_random_draws(200);
		test_output_stall();

		while (expected_values.size() != 0) @(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		while (expected_values.size() != 0)
			log_mismatch("missing result", expected_values.pop_front(), 'x);

		$display("covered %0d requests: %0d ranged, %0d empty-range, %0d full draws",
			sent_count, ranged_count, empty_count, sent_count - ranged_count - empty_count);
		$display("%0d results checked across %0d seed settings, %0d mismatches",
			checked_count, seed_settings, mismatches);
		if (mismatches == 0)
			$display("mwc_random_ranged_core test passed");
		else
			$display("mwc_random_ranged_core test failed");
		$finish;
	end

endmodule
